// ----- rtl/arlt_pkg.sv -----
package arlt_pkg;

    // table geometry
    localparam int SLOTS      = 8;
    localparam int OWNERS     = 8;
    localparam int LINE_SHIFT = 6;
    localparam int ADDR_BITS  = 48;

    // fixed field widths of the item ports
    localparam int FIELD_AW = 48;

    localparam int OWN_W  = (OWNERS > 1) ? $clog2(OWNERS) : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // address masks
    localparam logic [63:0]         ADDR_MASK64 = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - ADDR_BITS);
    localparam logic [FIELD_AW-1:0] ADDR_MASK   = ADDR_MASK64[FIELD_AW-1:0];
    localparam logic [63:0]         LINE_MASK64 = (64'd1 << LINE_SHIFT) - 64'd1;
    localparam logic [FIELD_AW-1:0] LINE_MASK   = LINE_MASK64[FIELD_AW-1:0];

    typedef enum logic {
        OP_LOCK   = 1'b0,
        OP_UNLOCK = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STAT_GRANTED  = 2'd0,
        STAT_BUSY     = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_RELEASED = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EVAL = 1'b1
    } t_back_state;

    typedef struct packed {
        logic                operation;
        logic [2:0]          owner;
        logic [FIELD_AW-1:0] range_start;
        logic [FIELD_AW-1:0] range_end;
        logic [2:0]          release_slot;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] granted_slot;
    } t_out_item;

    // classified command from front to back
    typedef struct packed {
        t_op                 op;
        logic [OWN_W-1:0]    owner;
        logic [SLOT_W-1:0]   slot;
        logic                rel_ok;
        logic [FIELD_AW-1:0] lo;
        logic [FIELD_AW-1:0] hi;
    } t_cmd;

    typedef struct packed {
        logic [FIELD_AW-1:0] start_addr;
        logic [FIELD_AW-1:0] end_addr;
    } t_slot_ent;

    typedef t_slot_ent [SLOTS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    // owner folded into the table count, by repeated subtraction
    function automatic logic [OWN_W-1:0] owner_idx(input logic [2:0] own);
        logic [8:0] v;
        v = {6'd0, own};
        for (int i = 0; i < 8; i++) begin
            if (v >= 9'(OWNERS)) begin
                v = v - 9'(OWNERS);
            end
        end
        return v[OWN_W-1:0];
    endfunction

endpackage

// ----- rtl/arlt_ram.sv -----
module arlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/arlt_front.sv -----
module arlt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  arlt_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output arlt_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_take
);
    import arlt_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    t_cmd       cls;
    logic [6:0] rel_ext;
    logic       do_push;
    logic       do_pop;

    // classify: widen the range to whole lines, fold owner and slot
    always_comb begin
        rel_ext    = 7'(i_item.release_slot);
        cls.op     = t_op'(i_item.operation);
        cls.owner  = owner_idx(i_item.owner);
        cls.slot   = rel_ext[SLOT_W-1:0];
        cls.rel_ok = rel_ext < 7'(SLOTS);
        cls.lo     = (i_item.range_start & ADDR_MASK) & ~LINE_MASK;
        cls.hi     = ((i_item.range_end & ADDR_MASK) & ~LINE_MASK) | (LINE_MASK & ADDR_MASK);
    end

    assign full        = (r_count == 2'd2);
    assign do_push     = push && !full;
    assign do_pop      = i_cmd_take && (r_count != 2'd0);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // two-entry command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

// ----- rtl/arlt_back.sv -----
module arlt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  arlt_pkg::t_cmd     i_cmd,
    output logic               o_cmd_take,
    output logic               empty,
    input  logic               pop,
    output arlt_pkg::t_out_item o_item
);
    import arlt_pkg::*;

    t_back_state       r_state;
    t_back_state       n_state;
    t_cmd              r_cmd;
    logic [SLOTS-1:0]  r_valid [OWNERS];
    t_out_item         r_ofifo [2];
    logic              r_owp;
    logic              r_orp;
    logic [1:0]        r_ocount;

    logic [ROW_W-1:0]  ram_rdata;
    logic [ROW_W-1:0]  ram_wdata;
    logic              ram_we;
    t_row              row;
    t_row              n_row;
    logic [SLOTS-1:0]  vrow;
    logic              conflict;
    logic              have_free;
    logic [SLOT_W-1:0] free_slot;
    logic [6:0]        fs_ext;
    logic              push_res;
    t_out_item         res;
    logic              clr_valid;
    logic              set_valid;
    logic              pop_ok;

    // owner rows of slot ranges
    arlt_ram #(
        .WIDTH(ROW_W),
        .DEPTH(OWNERS)
    ) u_rows (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_cmd.owner),
        .i_wdata(ram_wdata),
        .i_raddr(i_cmd.owner),
        .o_rdata(ram_rdata)
    );

    // overlap check and free-slot search over the row just read
    always_comb begin
        row       = t_row'(ram_rdata);
        vrow      = r_valid[r_cmd.owner];
        conflict  = 1'b0;
        have_free = 1'b0;
        free_slot = '0;
        for (int s = 0; s < SLOTS; s++) begin
            if (!vrow[s]) begin
                have_free = 1'b1;
                free_slot = SLOT_W'(s);
            end else if (r_cmd.lo <= row[s].end_addr && row[s].start_addr <= r_cmd.hi) begin
                conflict = 1'b1;
            end
        end
        fs_ext = 7'(free_slot);
        n_row  = row;
        n_row[free_slot].start_addr = r_cmd.lo;
        n_row[free_slot].end_addr   = r_cmd.hi;
        ram_wdata = ROW_W'(n_row);
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        o_cmd_take = 1'b0;
        ram_we     = 1'b0;
        push_res   = 1'b0;
        res        = '0;
        clr_valid  = 1'b0;
        set_valid  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && r_ocount != 2'd2) begin
                    o_cmd_take = 1'b1;
                    if (i_cmd.op == OP_UNLOCK) begin
                        push_res   = 1'b1;
                        res.status = STAT_RELEASED;
                        clr_valid  = i_cmd.rel_ok;
                    end else begin
                        n_state = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                push_res = 1'b1;
                n_state  = ST_IDLE;
                if (conflict) begin
                    res.status = STAT_BUSY;
                end else if (!have_free) begin
                    res.status = STAT_FULL;
                end else begin
                    res.status       = STAT_GRANTED;
                    res.granted_slot = fs_ext[2:0];
                    ram_we           = 1'b1;
                    set_valid        = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
    end

    // valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int o = 0; o < OWNERS; o++) begin
                r_valid[o] <= '0;
            end
        end else begin
            if (clr_valid) begin
                r_valid[i_cmd.owner][i_cmd.slot] <= 1'b0;
            end
            if (set_valid) begin
                r_valid[r_cmd.owner][free_slot] <= 1'b1;
            end
        end
    end

    // two-entry result queue
    assign pop_ok = pop && (r_ocount != 2'd0);
    assign empty  = (r_ocount == 2'd0);
    assign o_item = r_ofifo[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp    <= 1'b0;
            r_orp    <= 1'b0;
            r_ocount <= 2'd0;
        end else begin
            if (push_res) begin
                r_owp <= ~r_owp;
            end
            if (pop_ok) begin
                r_orp <= ~r_orp;
            end
            if (push_res && !pop_ok) begin
                r_ocount <= r_ocount + 2'd1;
            end else if (pop_ok && !push_res) begin
                r_ocount <= r_ocount - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_res) begin
            r_ofifo[r_owp] <= res;
        end
    end

    // result queue never overflows
    a_ocount_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocount != 2'd3)
        else $error("result queue count out of range");

    // a lock evaluation always returns to idle in the cycle after it
    a_eval_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EVAL |=> r_state == ST_IDLE)
        else $error("evaluation held more than one cycle");

    // commands are only taken while idle with room for a result
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> (r_state == ST_IDLE && r_ocount != 2'd2))
        else $error("command taken while busy or result queue full");

    // a grant is written back to the row it was read from
    a_grant_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        set_valid |-> (ram_we && !conflict && have_free))
        else $error("grant without matching row write");

endmodule

// ----- rtl/address_range_lock_table.sv -----
// Per-owner table of locked address ranges. Each input item either locks a range
// (widened to whole cache lines and checked against every occupied slot of its owner)
// or releases one slot; each item gives exactly one result: granted with its slot,
// busy on any overlap, full when no slot is free, or released. Items enter through
// a two-entry command queue (push/full) and results leave through a two-entry result
// queue (empty/pop). In the back end a lock first reads the owner's row from the slot
// memory, then compares, picks the highest free slot and writes the row back; an
// unlock is answered straight from idle. Slot valid bits are flip-flops cleared by
// reset, so the table is usable right after reset with no clearing pass.
module address_range_lock_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  arlt_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output arlt_pkg::t_out_item o_item
);
    import arlt_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_take;

    arlt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_take (cmd_take)
    );

    arlt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_cmd_take (cmd_take),
        .empty      (empty),
        .pop        (pop),
        .o_item     (o_item)
    );

endmodule

// ----- verif/tb_address_range_lock_table.sv -----
module tb_address_range_lock_table;
    timeunit 1ns;
    timeprecision 1ps;

    import arlt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 50;
    localparam int DRAIN_CYCLES = 20;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  i_item  = '0;
    logic      full;
    logic      empty;
    t_out_item o_item;

    // shadow copy of the per-owner lock tables
    logic                tbl_valid [OWNERS][SLOTS];
    logic [FIELD_AW-1:0] tbl_lo    [OWNERS][SLOTS];
    logic [FIELD_AW-1:0] tbl_hi    [OWNERS][SLOTS];

    t_out_item awaited_results[$];
    t_out_item want_item;
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        rx_wait        = 0;
    bit        no_idle        = 1'b0;

    address_range_lock_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item)
    );

    always #5 i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0d ns: %s", $time, msg);
        end
    endtask

    // apply one item to the shadow tables and return the answer it gets
    function automatic t_out_item apply_to_lock_table(input t_in_item it);
        t_out_item           res;
        int                  own;
        int                  free_slot;
        logic [FIELD_AW-1:0] lo;
        logic [FIELD_AW-1:0] hi;
        bit                  busy;
        bit                  have_free;
        res = '0;
        own = int'(it.owner) % OWNERS;
        if (it.operation == OP_UNLOCK) begin
            if (int'(it.release_slot) < SLOTS) begin
                tbl_valid[own][int'(it.release_slot)] = 1'b0;
            end
            res.status = STAT_RELEASED;
        end else begin
            // widen to whole lines
            lo = it.range_start & ADDR_MASK & ~LINE_MASK;
            hi = (it.range_end & ADDR_MASK & ~LINE_MASK) | (LINE_MASK & ADDR_MASK);
            busy      = 1'b0;
            have_free = 1'b0;
            free_slot = 0;
            // highest free slot wins, any overlap with a held range is busy
            for (int s = 0; s < SLOTS; s++) begin
                if (!tbl_valid[own][s]) begin
                    have_free = 1'b1;
                    free_slot = s;
                end else if (lo <= tbl_hi[own][s] && tbl_lo[own][s] <= hi) begin
                    busy = 1'b1;
                end
            end
            if (busy) begin
                res.status = STAT_BUSY;
            end else if (!have_free) begin
                res.status = STAT_FULL;
            end else begin
                tbl_valid[own][free_slot] = 1'b1;
                tbl_lo[own][free_slot]    = lo;
                tbl_hi[own][free_slot]    = hi;
                res.status       = STAT_GRANTED;
                res.granted_slot = 3'(free_slot);
            end
        end
        return res;
    endfunction

    function automatic logic [FIELD_AW-1:0] rand_addr();
        return FIELD_AW'({$urandom, $urandom});
    endfunction

    // unused fields get random content so every bit moves
    function automatic t_in_item lock_item(input int own, input logic [FIELD_AW-1:0] first,
                                           input logic [FIELD_AW-1:0] last);
        t_in_item it;
        it.operation    = OP_LOCK;
        it.owner        = 3'(own);
        it.range_start  = first;
        it.range_end    = last;
        it.release_slot = 3'($urandom);
        return it;
    endfunction

    function automatic t_in_item unlock_item(input int own, input int slot);
        t_in_item it;
        it.operation    = OP_UNLOCK;
        it.owner        = 3'(own);
        it.range_start  = rand_addr();
        it.range_end    = rand_addr();
        it.release_slot = 3'(slot);
        return it;
    endfunction

    // send one item; push stays high when the next item follows at once
    task automatic send_item(input t_in_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        awaited_results.push_back(apply_to_lock_table(it));
    endtask

    // result side: random pop stalls and compare with the oldest answer
    always @(posedge i_clk) begin
        if (pop && !empty) begin
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result with none awaited: status %0d slot %0d",
                                          o_item.status, o_item.granted_slot));
            end else begin
                want_item = awaited_results.pop_front();
                if (o_item.status !== want_item.status) begin
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              o_item.status, want_item.status));
                end
                if (o_item.granted_slot !== want_item.granted_slot) begin
                    report_mismatch($sformatf("granted_slot got %0d expected %0d",
                                              o_item.granted_slot, want_item.granted_slot));
                end
            end
            rx_wait = no_idle ? 0 : $urandom_range(0, 6);
        end else if (rx_wait > 0) begin
            rx_wait--;
        end
        pop <= i_rst_n && (rx_wait == 0);
    end

    // address extremes, inverted ranges, line sharing, releases of free slots
    task automatic test_field_extremes();
        send_item(lock_item(0, '0, '0));
        send_item(lock_item(0, '1, '1));
        // start after end is stored as is and does not even overlap itself
        send_item(lock_item(0, 48'h1000, 48'h0F00));
        send_item(lock_item(0, 48'h1000, 48'h0F00));
        send_item(lock_item(0, 48'h40, 48'h7F));
        // same line as the first lock
        send_item(lock_item(0, 48'h3F, 48'h3F));
        send_item(lock_item(7, '0, '1));
        send_item(lock_item(7, 48'h8000_0000_0000, 48'h8000_0000_0000));
        send_item(unlock_item(0, 7));
        // release of a slot that is already free
        send_item(unlock_item(7, 0));
        send_item(unlock_item(7, 7));
        send_item(lock_item(0, '0, 48'h3F));
    endtask

    // fill one table, then full, busy over full, and slot reuse
    task automatic test_full_table();
        for (int i = 0; i < SLOTS; i++) begin
            send_item(lock_item(3, FIELD_AW'(i) << 8, (FIELD_AW'(i) << 8) + 48'h40));
        end
        send_item(lock_item(3, 48'h1_0000, 48'h1_0000));
        send_item(lock_item(3, 48'h100, 48'h100));
        send_item(unlock_item(3, 2));
        send_item(lock_item(3, 48'h2_0000, 48'h2_00FF));
    endtask

    // mostly clustered locks on one owner per phase so tables fill and collide
    task automatic test_random_traffic(input int n_items);
        t_in_item            it;
        int                  focus;
        int                  own;
        int                  pick;
        logic [FIELD_AW-1:0] region;
        logic [FIELD_AW-1:0] first;
        logic [FIELD_AW-1:0] last;
        focus  = 0;
        region = '0;
        for (int i = 0; i < n_items; i++) begin
            if (i % 150 == 0) begin
                focus = $urandom_range(0, 7);
                case ($urandom_range(0, 2))
                    0:       region = '0;
                    1:       region = 48'hFFFF_FFFF_0000;
                    default: region = rand_addr() & ~48'hFFFF;
                endcase
                no_idle = ($urandom_range(0, 3) == 0);
            end
            own  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : focus;
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                it = unlock_item(own, $urandom_range(0, 7));
            end else if (pick < 45) begin
                it = lock_item(own, rand_addr(), rand_addr());
            end else begin
                first = region | (FIELD_AW'($urandom_range(0, 63)) << LINE_SHIFT)
                        | FIELD_AW'($urandom_range(0, 63));
                last  = first + FIELD_AW'($urandom_range(0, 255));
                if ($urandom_range(0, 19) == 0) begin
                    it = lock_item(own, last, first);
                end else begin
                    it = lock_item(own, first, last);
                end
            end
            send_item(it);
        end
    endtask

    initial begin
        for (int o = 0; o < OWNERS; o++) begin
            for (int s = 0; s < SLOTS; s++) begin
                tbl_valid[o][s] = 1'b0;
                tbl_lo[o][s]    = '0;
                tbl_hi[o][s]    = '0;
            end
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_full_table();
        test_random_traffic(1350);
        push <= 1'b0;

        // drain outstanding results, then watch for strays
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
